/* sv/mcm_pkg.sv */
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, codes and defaults of the motif count matrix site update unit.
// ----------------------------------------------------------------------------
package mcm_pkg;

    // Defaults for the top-level parameters
    localparam int SPAN_MAX_DEF    = 32;
    localparam int MAX_SEQS_DEF    = 64;
    localparam int SEQ_LEN_MAX_DEF = 1024;

    // Fixed alphabet and field widths
    localparam int NUM_SYMBOLS = 4;
    localparam int CMD_W       = 3;
    localparam int SEQ_IDX_W   = 6;
    localparam int POSITION_W  = 11;
    localparam int POS_W       = 10;     // magnitude bits of a non-negative position
    localparam int SYM_W       = 2;
    localparam int COL_W       = 5;
    localparam int CNT_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int SPAN_CFG_W  = 6;

    localparam logic [CNT_W-1:0]      CNT_TOP    = 7'd127;
    localparam logic [SPAN_CFG_W-1:0] SPAN_RESET = 6'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_REBUILD = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_BUSY  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_REBUILD,
        ST_SITE_RD,
        ST_WALK_ISSUE,
        ST_WALK_SYM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]             cmd;
        logic [SEQ_IDX_W-1:0]         seq_index;
        logic signed [POSITION_W-1:0] position;
        logic [SYM_W-1:0]             symbol;
        logic [COL_W-1:0]             column;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] site_count;
        logic [CNT_W-1:0] count_value;
        status_t          status;
    } result_t;

endpackage

/* sv/mcm_ram.sv */
// ----------------------------------------------------------------------------
// mcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/mcm_engine.sv */
// ----------------------------------------------------------------------------
// mcm_engine
// Command sequencer around the symbol store, site table and count matrix
// memories; walks motif windows with one count read-modify-write per column.
// ----------------------------------------------------------------------------
module mcm_engine #(
    parameter int SPAN_MAX    = mcm_pkg::SPAN_MAX_DEF,
    parameter int MAX_SEQS    = mcm_pkg::MAX_SEQS_DEF,
    parameter int SEQ_LEN_MAX = mcm_pkg::SEQ_LEN_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  mcm_pkg::item_t                    item,
    input  logic [mcm_pkg::SPAN_CFG_W-1:0]    motif_span,
    output logic                              res_valid,
    input  logic                              res_ready,
    output mcm_pkg::result_t                  res
);

    import mcm_pkg::*;

    localparam int SITE_AW     = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int STORE_DEPTH = MAX_SEQS * SEQ_LEN_MAX;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_DEPTH   = SPAN_MAX * NUM_SYMBOLS;
    localparam int CNT_AW      = $clog2(CNT_DEPTH);
    localparam int SPAN_W      = $clog2(SPAN_MAX + 1);
    localparam int LEN_W       = $clog2(SEQ_LEN_MAX + 1);
    localparam int PCNT_W      = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;

    // Control and walk registers
    state_t               state_reg,    state_next;
    logic [STORE_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [SITE_AW-1:0]   seq_reg,      seq_next;
    logic [SITE_AW-1:0]   iter_reg,     iter_next;
    logic                 rebuild_reg,  rebuild_next;
    logic                 dir_up_reg,   dir_up_next;
    logic [SPAN_W-1:0]    col_reg,      col_next;
    logic [PCNT_W-1:0]    pos_reg,      pos_next;
    logic [STORE_AW-1:0]  addr_reg,     addr_next;
    logic [CNT_AW-1:0]    cidx_reg,     cidx_next;
    logic                 cvld_reg,     cvld_next;
    logic                 pend_reg,     pend_next;
    status_t              status_reg,   status_next;
    logic [CNT_W-1:0]     value_reg,    value_next;
    logic [CNT_W-1:0]     occ_reg,      occ_next;
    logic [MAX_SEQS-1:0]  site_vld_reg, site_vld_next;
    logic [CNT_DEPTH-1:0] cnt_vld_reg,  cnt_vld_next;

    // Memory ports
    logic                 st_we, st_re;
    logic [STORE_AW-1:0]  st_waddr, st_raddr;
    logic [SYM_W-1:0]     st_wdata, st_rdata;
    logic                 site_we, site_re;
    logic [SITE_AW-1:0]   site_waddr, site_raddr;
    logic [POS_W-1:0]     site_wdata, site_rdata;
    logic                 cnt_we, cnt_re;
    logic [CNT_AW-1:0]    cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;

    // Decode helpers
    logic [SPAN_W-1:0]    span_eff;
    logic                 seq_ok;
    logic [SITE_AW-1:0]   sidx;
    logic                 neg;
    logic [POS_W-1:0]     pos_mag;
    logic [CNT_AW-1:0]    idx;
    logic [CNT_W-1:0]     cur_cnt;

    mcm_ram #(.WIDTH(SYM_W), .DEPTH(STORE_DEPTH), .ADDR_W(STORE_AW)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mcm_ram #(.WIDTH(POS_W), .DEPTH(MAX_SEQS), .ADDR_W(SITE_AW)) u_sites (
        .clk   (clk),
        .we    (site_we),
        .waddr (site_waddr),
        .wdata (site_wdata),
        .re    (site_re),
        .raddr (site_raddr),
        .rdata (site_rdata)
    );

    mcm_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH), .ADDR_W(CNT_AW)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Clamp span and split the incoming beat
    always_comb
    begin
        span_eff = (int'(motif_span) > SPAN_MAX) ? SPAN_W'(SPAN_MAX) : SPAN_W'(motif_span);
        seq_ok   = int'(item.seq_index) < MAX_SEQS;
        sidx     = SITE_AW'(item.seq_index);
        neg      = item.position[POSITION_W-1];
        pos_mag  = item.position[POS_W-1:0];
        cur_cnt  = cvld_reg ? cnt_rdata : '0;
    end

    // Next state, memory controls and outputs
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        seq_next      = seq_reg;
        iter_next     = iter_reg;
        rebuild_next  = rebuild_reg;
        dir_up_next   = dir_up_reg;
        col_next      = col_reg;
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        cidx_next     = cidx_reg;
        cvld_next     = cvld_reg;
        pend_next     = pend_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        occ_next      = occ_reg;
        site_vld_next = site_vld_reg;
        cnt_vld_next  = cnt_vld_reg;

        st_we      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_re      = 1'b0;
        st_raddr   = addr_reg;
        site_we    = 1'b0;
        site_waddr = sidx;
        site_wdata = pos_mag;
        site_re    = 1'b0;
        site_raddr = sidx;
        cnt_we     = 1'b0;
        cnt_waddr  = cidx_reg;
        cnt_wdata  = '0;
        cnt_re     = 1'b0;
        cnt_raddr  = '0;
        idx        = '0;

        item_ready = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_DONE);

        unique case (state_reg)
            // Zero the symbol store one entry per cycle after reset
            ST_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_addr_reg;
                if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            // Decode the accepted beat
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    status_next = STAT_OK;
                    value_next  = '0;
                    state_next  = ST_DONE;
                    unique case (item.cmd)
                        CMD_LOAD:
                        begin
                            if (!seq_ok || neg || int'(pos_mag) >= SEQ_LEN_MAX
                                || int'(item.symbol) >= NUM_SYMBOLS)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = STORE_AW'(int'(item.seq_index) * SEQ_LEN_MAX
                                                     + int'(pos_mag));
                                st_wdata = item.symbol;
                            end
                        end
                        CMD_ADD:
                        begin
                            priority if (!seq_ok)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (site_vld_reg[sidx])
                            begin
                                status_next = STAT_BUSY;
                            end
                            else if (neg)
                            begin
                                status_next = STAT_OK;
                            end
                            else if (int'(pos_mag) + int'(span_eff) > SEQ_LEN_MAX)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                site_we             = 1'b1;
                                site_vld_next[sidx] = 1'b1;
                                if (occ_reg < CNT_TOP)
                                begin
                                    occ_next = occ_reg + 1'b1;
                                end
                                dir_up_next  = 1'b1;
                                rebuild_next = 1'b0;
                                col_next     = '0;
                                pos_next     = PCNT_W'(pos_mag);
                                addr_next    = STORE_AW'(int'(item.seq_index) * SEQ_LEN_MAX
                                                         + int'(pos_mag));
                                pend_next    = 1'b0;
                                state_next   = ST_WALK_ISSUE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!seq_ok)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (site_vld_reg[sidx])
                            begin
                                site_vld_next[sidx] = 1'b0;
                                if (occ_reg != '0)
                                begin
                                    occ_next = occ_reg - 1'b1;
                                end
                                site_re      = 1'b1;
                                seq_next     = sidx;
                                dir_up_next  = 1'b0;
                                rebuild_next = 1'b0;
                                state_next   = ST_SITE_RD;
                            end
                        end
                        CMD_REBUILD:
                        begin
                            cnt_vld_next = '0;
                            iter_next    = '0;
                            rebuild_next = 1'b1;
                            dir_up_next  = 1'b1;
                            state_next   = ST_REBUILD;
                        end
                        CMD_READ:
                        begin
                            if (int'(item.column) >= SPAN_MAX
                                || int'(item.symbol) >= NUM_SYMBOLS)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                idx        = CNT_AW'(int'(item.column) * NUM_SYMBOLS
                                                     + int'(item.symbol));
                                cnt_re     = 1'b1;
                                cnt_raddr  = idx;
                                cvld_next  = cnt_vld_reg[idx];
                                state_next = ST_CNT_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            // Capture the count read
            ST_CNT_RD:
            begin
                value_next = cur_cnt;
                state_next = ST_DONE;
            end

            // Scan the site slots for occupied entries
            ST_REBUILD:
            begin
                if (site_vld_reg[iter_reg])
                begin
                    site_re    = 1'b1;
                    site_raddr = iter_reg;
                    seq_next   = iter_reg;
                    state_next = ST_SITE_RD;
                end
                else if (iter_reg == SITE_AW'(MAX_SEQS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end

            // Start a window walk from the stored site start
            ST_SITE_RD:
            begin
                addr_next  = STORE_AW'(int'(seq_reg) * SEQ_LEN_MAX + int'(site_rdata));
                pos_next   = PCNT_W'(site_rdata);
                col_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_WALK_ISSUE;
            end

            // Retire the pending count, issue the next symbol read
            ST_WALK_ISSUE:
            begin
                if (pend_reg)
                begin
                    cnt_we = 1'b1;
                    if (dir_up_reg)
                    begin
                        cnt_wdata = (cur_cnt < CNT_TOP) ? cur_cnt + 1'b1 : cur_cnt;
                    end
                    else
                    begin
                        cnt_wdata = (cur_cnt != '0) ? cur_cnt - 1'b1 : cur_cnt;
                    end
                    cnt_vld_next[cidx_reg] = 1'b1;
                end
                pend_next = 1'b0;
                if (col_reg < span_eff && int'(pos_reg) < SEQ_LEN_MAX)
                begin
                    st_re      = 1'b1;
                    state_next = ST_WALK_SYM;
                end
                else if (rebuild_reg)
                begin
                    if (iter_reg == SITE_AW'(MAX_SEQS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        iter_next  = iter_reg + 1'b1;
                        state_next = ST_REBUILD;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // Symbol is back: read its count, advance the column
            ST_WALK_SYM:
            begin
                if (int'(st_rdata) < NUM_SYMBOLS)
                begin
                    idx       = CNT_AW'(int'(col_reg) * NUM_SYMBOLS + int'(st_rdata));
                    cnt_re    = 1'b1;
                    cnt_raddr = idx;
                    cidx_next = idx;
                    cvld_next = cnt_vld_reg[idx];
                    pend_next = 1'b1;
                end
                col_next   = col_reg + 1'b1;
                pos_next   = pos_reg + 1'b1;
                addr_next  = addr_reg + 1'b1;
                state_next = ST_WALK_ISSUE;
            end

            // Hand the result over
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.site_count  = occ_reg;
        res.count_value = value_reg;
        res.status      = status_reg;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            seq_reg      <= '0;
            iter_reg     <= '0;
            rebuild_reg  <= 1'b0;
            dir_up_reg   <= 1'b0;
            col_reg      <= '0;
            pos_reg      <= '0;
            addr_reg     <= '0;
            cidx_reg     <= '0;
            cvld_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            status_reg   <= STAT_OK;
            value_reg    <= '0;
            occ_reg      <= '0;
            site_vld_reg <= '0;
            cnt_vld_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            seq_reg      <= seq_next;
            iter_reg     <= iter_next;
            rebuild_reg  <= rebuild_next;
            dir_up_reg   <= dir_up_next;
            col_reg      <= col_next;
            pos_reg      <= pos_next;
            addr_reg     <= addr_next;
            cidx_reg     <= cidx_next;
            cvld_reg     <= cvld_next;
            pend_reg     <= pend_next;
            status_reg   <= status_next;
            value_reg    <= value_next;
            occ_reg      <= occ_next;
            site_vld_reg <= site_vld_next;
            cnt_vld_reg  <= cnt_vld_next;
        end
    end

endmodule

/* sv/motif_count_matrix_site_update_unit.sv */
// ----------------------------------------------------------------------------
// motif_count_matrix_site_update_unit
// Gibbs motif sampler count matrix keeper: symbol store, site table, counts.
// ----------------------------------------------------------------------------
// One command beat gives one result beat. An add or remove walks the window
// column by column (symbol store read, then count read-modify-write); a
// rebuild scans every sequence slot and walks the window of each occupied
// site. After reset the symbol store is zeroed one entry per cycle,
// MAX_SEQS*SEQ_LEN_MAX entries (65536 by default), with s_axis_tready low;
// configuration writes are taken at any time. A new command is taken while
// the previous result waits in the output register.
module motif_count_matrix_site_update_unit #(
    parameter int SPAN_MAX    = mcm_pkg::SPAN_MAX_DEF,
    parameter int MAX_SEQS    = mcm_pkg::MAX_SEQS_DEF,
    parameter int SEQ_LEN_MAX = mcm_pkg::SEQ_LEN_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // seq_index, position, symbol, column
    input  logic [2:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // site_count, count_value, zero pad
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // motif_span
);

    import mcm_pkg::*;

    logic [SPAN_CFG_W-1:0] span_reg;
    item_t                 item;
    result_t               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  out_valid_reg;
    result_t               out_data_reg;

    // Unpack the command beat
    always_comb
    begin
        item.cmd       = s_axis_tuser;
        item.seq_index = s_axis_tdata[5:0];
        item.position  = s_axis_tdata[16:6];
        item.symbol    = s_axis_tdata[18:17];
        item.column    = s_axis_tdata[23:19];
    end

    // Hold the span register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            span_reg <= cfg_data;
        end
    end

    mcm_engine #(
        .SPAN_MAX    (SPAN_MAX),
        .MAX_SEQS    (MAX_SEQS),
        .SEQ_LEN_MAX (SEQ_LEN_MAX)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .motif_span (span_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg.count_value, out_data_reg.site_count};
    assign m_axis_tuser  = out_data_reg.status;

endmodule

/* sv/mcm_checker.sv */
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks of the motif count matrix site update unit.
// ----------------------------------------------------------------------------
module mcm_checker #(
    parameter int MAX_SEQS = mcm_pkg::MAX_SEQS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    import mcm_pkg::*;

    localparam int SITE_LIMIT = (MAX_SEQS < 127) ? MAX_SEQS : 127;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // One command in flight: ready drops after each accepted beat
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while one is in flight");

    // Flagged results carry no count
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[13:7] == 7'd0)
        else $error("flagged result carries a count");

    // Site count cannot exceed the number of slots
    a_site_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> int'(m_axis_tdata[6:0]) <= SITE_LIMIT)
        else $error("site count above slot count");

endmodule

bind motif_count_matrix_site_update_unit mcm_checker #(.MAX_SEQS(MAX_SEQS)) u_mcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/motif_count_ledger_pkg.sv */
// ----------------------------------------------------------------------------
// motif_count_ledger_pkg
// Scoreboard for the motif count matrix unit: predicts each result beat from
// the accepted command beats and checks the beats that come back in order.
// ----------------------------------------------------------------------------
package motif_count_ledger_pkg;

    import mcm_pkg::*;

    localparam int SEQ_LEN   = SEQ_LEN_MAX_DEF;
    localparam int SEQ_SLOTS = MAX_SEQS_DEF;
    localparam int COLS      = SPAN_MAX_DEF;
    localparam int MAX_LINES = 200;

    class site_count_ledger;

        bit [SYM_W-1:0]      symbol_store [SEQ_SLOTS*SEQ_LEN];
        bit                  site_held    [SEQ_SLOTS];
        bit [POS_W-1:0]      site_start   [SEQ_SLOTS];
        bit [CNT_W-1:0]      col_count    [COLS*NUM_SYMBOLS];
        bit [CNT_W-1:0]      held_sites;
        bit [SPAN_CFG_W-1:0] span_reg;
        result_t             awaited_q [$];
        int                  errors;

        function new();
            span_reg = SPAN_RESET;
            held_sites = '0;
            errors = 0;
        endfunction

        // Effective window length: the register clipped to the matrix width
        function int window_len();
            return (int'(span_reg) < COLS) ? int'(span_reg) : COLS;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Raise or lower one count per window column; stop at the store end
        function void walk_window(input int seq, input int start, input bit raise);
            int len;
            int p;
            int idx;
            len = window_len();
            for (int m = 0; m < len; m++)
            begin
                p = start + m;
                if (p >= SEQ_LEN)
                    break;
                idx = m * NUM_SYMBOLS + symbol_store[seq * SEQ_LEN + p];
                if (raise)
                begin
                    if (col_count[idx] != CNT_TOP)
                        col_count[idx]++;
                end
                else if (col_count[idx] != 0)
                    col_count[idx]--;
            end
        endfunction

        // Apply one accepted command beat and queue the result it must give
        function void note_command(input item_t it);
            result_t want;
            int      seq;
            int      pos;
            bit      neg;
            seq = it.seq_index;
            neg = it.position[POSITION_W-1];
            pos = it.position[POS_W-1:0];
            want.count_value = '0;
            want.status = STAT_OK;
            case (it.cmd)
                CMD_LOAD:
                begin
                    if (seq >= SEQ_SLOTS || neg || pos >= SEQ_LEN || it.symbol >= NUM_SYMBOLS)
                        want.status = STAT_RANGE;
                    else
                        symbol_store[seq * SEQ_LEN + pos] = it.symbol;
                end
                CMD_ADD:
                begin
                    if (seq >= SEQ_SLOTS)
                        want.status = STAT_RANGE;
                    else if (site_held[seq])
                        want.status = STAT_BUSY;
                    else if (neg)
                        want.status = STAT_OK;
                    else if (pos + window_len() > SEQ_LEN)
                        want.status = STAT_RANGE;
                    else
                    begin
                        walk_window(seq, pos, 1'b1);
                        site_held[seq] = 1'b1;
                        site_start[seq] = POS_W'(pos);
                        if (held_sites != CNT_TOP)
                            held_sites++;
                    end
                end
                CMD_REMOVE:
                begin
                    if (seq >= SEQ_SLOTS)
                        want.status = STAT_RANGE;
                    else if (site_held[seq])
                    begin
                        walk_window(seq, site_start[seq], 1'b0);
                        site_held[seq] = 1'b0;
                        site_start[seq] = '0;
                        if (held_sites != 0)
                            held_sites--;
                    end
                end
                CMD_REBUILD:
                begin
                    foreach (col_count[i])
                        col_count[i] = '0;
                    for (int s = 0; s < SEQ_SLOTS; s++)
                        if (site_held[s])
                            walk_window(s, site_start[s], 1'b1);
                end
                CMD_READ:
                begin
                    if (it.column >= COLS || it.symbol >= NUM_SYMBOLS)
                        want.status = STAT_RANGE;
                    else
                        want.count_value = col_count[it.column * NUM_SYMBOLS + it.symbol];
                end
                default:
                    ;
            endcase
            want.site_count = held_sites;
            awaited_q.push_back(want);
        endfunction

        task report(input string what, input logic [31:0] exp, input logic [31:0] got);
            errors++;
            if (errors <= MAX_LINES)
                $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, exp, got);
        endtask

        // Compare one result beat against the oldest prediction
        task check_result(input result_t got);
            result_t want;
            if (awaited_q.size() == 0)
                report("result beat with no command waiting", 0, got.site_count);
            else
            begin
                want = awaited_q.pop_front();
                if (got.site_count !== want.site_count)
                    report("site_count", want.site_count, got.site_count);
                if (got.count_value !== want.count_value)
                    report("count_value", want.count_value, got.count_value);
                if (got.status !== want.status)
                    report("status", want.status, got.status);
            end
        endtask

    endclass

endpackage

/* bench/motif_count_matrix_site_update_unit_tb.sv */
// ----------------------------------------------------------------------------
// motif_count_matrix_site_update_unit_tb
// Drives command beats into the motif count matrix unit with random gaps and
// stalls, predicts every result beat and checks it field by field. Covers a
// directed pass, span skew rounds that push counts to both limits, and random
// phases over several span settings.
// ----------------------------------------------------------------------------
module motif_count_matrix_site_update_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mcm_pkg::*;
    import motif_count_ledger_pkg::*;

    localparam int                WATCH_LIMIT  = 200000;
    localparam int                HOT_LIMIT    = 47;
    localparam int                TAIL_CYCLES  = 80;
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = CMD_W'(CMD_READ + 1);
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = '1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // seq_index, position, symbol, column
    logic [2:0]  s_axis_tuser;    // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // site_count, count_value, zero pad
    logic [1:0]  m_axis_tuser;    // status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;        // motif_span

    site_count_ledger ledger = new();
    bit               calm_sender;
    bit               calm_sink;
    int               idle_cycles = 0;

    motif_count_matrix_site_update_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t make_cmd(input logic [CMD_W-1:0] cmd, input int seq,
                                       input int pos, input int sym, input int col);
        item_t it;
        it.cmd       = cmd;
        it.seq_index = seq[SEQ_IDX_W-1:0];
        it.position  = pos[POSITION_W-1:0];
        it.symbol    = sym[SYM_W-1:0];
        it.column    = col[COL_W-1:0];
        return it;
    endfunction

    // Random command, mostly on a few hot sequences and low positions
    function automatic item_t draw_command();
        item_t it;
        int    len;
        int    pick;
        int    sub;
        int    seq;
        int    pos_val;
        len = ledger.window_len();
        seq = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SEQ_SLOTS - 1) : $urandom_range(0, 7);
        pos_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SEQ_LEN - 1)
                                              : $urandom_range(0, HOT_LIMIT);
        it = make_cmd(CMD_LOAD, seq, 0, $urandom_range(0, NUM_SYMBOLS - 1),
                      $urandom_range(0, COLS - 1));
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 19);
        if (pick < 35)
        begin
            if (sub == 0)
                pos_val = -int'($urandom_range(1, SEQ_LEN));
        end
        else if (pick < 55)
        begin
            it.cmd = CMD_ADD;
            if (sub < 2)
                pos_val = -int'($urandom_range(1, SEQ_LEN));
            else if (sub < 4)
            begin
                // hug the end of the store: some windows fit, some spill over
                pos_val = SEQ_LEN - len + int'($urandom_range(0, 6)) - 3;
                if (pos_val > SEQ_LEN - 1)
                    pos_val = SEQ_LEN - 1;
            end
        end
        else if (pick < 72)
            it.cmd = CMD_REMOVE;
        else if (pick < 94)
        begin
            it.cmd = CMD_READ;
            if (len > 0 && sub < 15)
                it.column = COL_W'($urandom_range(0, len - 1));
        end
        else if (pick < 96)
            it.cmd = CMD_REBUILD;
        else
            it.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        it.position = pos_val[POSITION_W-1:0];
        return it;
    endfunction

    // Present one command beat and hold it until taken
    task automatic push_command(input item_t it);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.column, it.symbol, it.position, it.seq_index};
        s_axis_tuser  <= it.cmd;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        ledger.note_command(it);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
    endtask

    task automatic set_span(input int span);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= span[SPAN_CFG_W-1:0];
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ledger.span_reg = span[SPAN_CFG_W-1:0];
    endtask

    // Add a site on every slot at one span, drop them all at another
    task automatic skew_round(input int add_span, input int drop_span);
        set_span(add_span);
        for (int s = 0; s < SEQ_SLOTS; s++)
            push_command(make_cmd(CMD_ADD, s, $urandom_range(0, SEQ_LEN - COLS), 0, 0));
        set_span(drop_span);
        for (int s = 0; s < SEQ_SLOTS; s++)
            push_command(make_cmd(CMD_REMOVE, s, 0, 0, 0));
    endtask

    task automatic read_sweep(input int sym);
        for (int c = 0; c < COLS; c++)
            push_command(make_cmd(CMD_READ, 0, 0, sym, c));
    endtask

    task automatic random_phase(input int span, input int count);
        set_span(span);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                calm_sender = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) == 0)
                settle();
            push_command(draw_command());
        end
        calm_sender = 1'b0;
    endtask

    // Result sink: random stalls, with stall-free stretches
    initial
    begin : result_sink
        result_t got;
        int      stall;
        int      beats;
        beats = 0;
        calm_sink = 1'b0;
        forever
        begin
            stall = calm_sink ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (m_axis_tvalid !== 1'b1)
                @(posedge clk);
            got.site_count  = m_axis_tdata[CNT_W-1:0];
            got.count_value = m_axis_tdata[2*CNT_W-1:CNT_W];
            got.status      = status_t'(m_axis_tuser);
            ledger.check_result(got);
            beats++;
            if (beats % 40 == 0)
                calm_sink = ($urandom_range(0, 2) == 0);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main stimulus
    initial
    begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        calm_sender   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at a short span
        set_span(5);
        push_command(make_cmd(CMD_LOAD, 0, 0, 3, 0));
        push_command(make_cmd(CMD_LOAD, 0, 1, 2, 31));
        push_command(make_cmd(CMD_LOAD, SEQ_SLOTS - 1, SEQ_LEN - 1, 1, 0));
        push_command(make_cmd(CMD_LOAD, 5, -1, 3, 0));
        push_command(make_cmd(CMD_LOAD, 5, -SEQ_LEN, 3, 0));
        push_command(make_cmd(CMD_ADD, 0, 0, 0, 0));
        push_command(make_cmd(CMD_ADD, 0, 5, 0, 0));
        push_command(make_cmd(CMD_ADD, 1, -1, 0, 0));
        push_command(make_cmd(CMD_ADD, 2, SEQ_LEN - 4, 0, 0));
        push_command(make_cmd(CMD_ADD, SEQ_SLOTS - 1, SEQ_LEN - 5, 0, 0));
        push_command(make_cmd(CMD_READ, 0, 0, 3, 0));
        push_command(make_cmd(CMD_READ, 0, 0, 2, 1));
        push_command(make_cmd(CMD_READ, 0, 0, 1, 4));
        push_command(make_cmd(CMD_READ, 0, 0, 3, COLS - 1));
        push_command(make_cmd(CMD_REMOVE, 1, 0, 0, 0));
        push_command(make_cmd(CMD_REMOVE, 0, 0, 0, 0));
        push_command(make_cmd(CMD_READ, 0, 0, 3, 0));
        push_command(make_cmd(CMD_REBUILD, 0, 0, 0, 0));
        push_command(make_cmd(CMD_READ, 0, 0, 1, 4));
        push_command(make_cmd(CMD_READ, 0, 0, 0, 2));
        push_command(make_cmd(CMD_SPARE_LO, 3, 7, 1, 9));
        push_command(make_cmd(CMD_SPARE_HI, SEQ_SLOTS - 1, -1, 3, COLS - 1));
        push_command(make_cmd(CMD_REMOVE, SEQ_SLOTS - 1, 0, 0, 0));
        push_command(make_cmd(CMD_READ, 0, 0, 0, 0));

        // Drive counts to saturation, then back down to the floor
        skew_round(COLS, 1);
        skew_round(COLS, 1);
        read_sweep(0);
        skew_round(1, COLS);
        skew_round(1, COLS);
        read_sweep(0);
        push_command(make_cmd(CMD_REBUILD, 0, 0, 0, 0));

        // Random phases over spans including both register extremes
        random_phase(0, 220);
        random_phase((1 << SPAN_CFG_W) - 1, 220);
        random_phase(SPAN_RESET, 220);
        random_phase(2, 220);
        random_phase($urandom_range(1, COLS), 220);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
